[src/ccp_pkg.sv]
// ----------------------------------------------------------------------------
// Camera pan/tilt pointing package
// Shared widths, CORDIC arctangent table and angle conversion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ccp_pkg;

  // Fixed widths of the datapath.
  localparam int ANG_W     = 16;   // binary angle on the ports
  localparam int TRIG_W    = 27;   // Q24 sine and cosine with growth room
  localparam int PH_W      = 34;   // 32-bit phase plus guard bits
  localparam int NORM_W    = 35;   // normalized vector components
  localparam int VEC_W     = 38;   // vectoring CORDIC working width
  localparam int FRAC_W    = 24;   // fraction bits of sine, cosine and gain
  localparam int SHIFT_W   = 6;    // normalizing shift amount
  localparam int NORM_EXP  = 32;   // components are scaled up to 2^32
  localparam int GAIN_LO_W = 18;   // low slice of the magnitude multiply
  localparam int GAIN_HI_W = VEC_W - 1 - GAIN_LO_W;

  localparam logic [FRAC_W-1:0] GAIN_Q24 = 24'd10187457;
  localparam logic signed [ANG_W-1:0] HALF_PI_OUT = 16'sd16384;

  // Arctangent of 2^-i as a phase where 2^32 is one turn.
  function automatic logic signed [PH_W-1:0] atan_phase(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return $signed({{(PH_W-32){1'b0}}, v});
  endfunction

  // Round a phase to a binary angle and clamp it to a quarter turn.
  function automatic logic signed [ANG_W-1:0] phase_to_out(input logic signed [PH_W-1:0] ph);
    logic signed [PH_W:0]    t;
    logic signed [PH_W-16:0] v;
    logic signed [ANG_W-1:0] res;
    t = $signed({ph[PH_W-1], ph}) + $signed((PH_W+1)'(32768));
    v = t[PH_W:16];
    if (v > $signed((PH_W-15)'(16384))) begin
      res = HALF_PI_OUT;
    end else if (v < -$signed((PH_W-15)'(16384))) begin
      res = -HALF_PI_OUT;
    end else begin
      res = v[ANG_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/ccp_sincos.sv]
// ----------------------------------------------------------------------------
// Three-lane sine/cosine pipeline
// Rotation-mode CORDIC, one step per register stage, for heading, pitch and
// roll side by side; an opaque word travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_sincos
  import ccp_pkg::*;
#(
  parameter int STEPS = 16,
  parameter int PW    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [2:0][ANG_W-1:0]       in_ang,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_v,
  output logic [2:0][TRIG_W-1:0]      out_c,
  output logic [2:0][TRIG_W-1:0]      out_s,
  output logic [PW-1:0]               out_pay
);

  logic [STEPS:0]                v_r;
  logic signed [TRIG_W-1:0]      x_r   [0:STEPS][3];
  logic signed [TRIG_W-1:0]      y_r   [0:STEPS][3];
  logic signed [PH_W-1:0]        z_r   [0:STEPS][3];
  logic [2:0]                    flip_r[0:STEPS];
  logic [PW-1:0]                 pay_r [0:STEPS];
  logic [2:0]                    flip_nxt;
  logic signed [PH_W-1:0]        z0_nxt[3];
  logic                          out_v_r;
  logic [2:0][TRIG_W-1:0]        c_r;
  logic [2:0][TRIG_W-1:0]        s_r;
  logic [PW-1:0]                 out_pay_r;

  // Fold each angle into the right half plane and form the start phase.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      flip_nxt[l] = (in_ang[l][ANG_W-1:ANG_W-2] == 2'b01) ||
                    (in_ang[l][ANG_W-1:ANG_W-2] == 2'b10);
      z0_nxt[l]   = $signed({{(PH_W-32){in_ang[l][ANG_W-1] ^ flip_nxt[l]}},
                             in_ang[l][ANG_W-1] ^ flip_nxt[l],
                             in_ang[l][ANG_W-2:0], 16'h0000});
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      x_r[0][l] <= $signed({{(TRIG_W-FRAC_W){1'b0}}, GAIN_Q24});
      y_r[0][l] <= '0;
      z_r[0][l] <= z0_nxt[l];
    end
    flip_r[0] <= flip_nxt;
    pay_r[0]  <= in_pay;
  end

  // One CORDIC micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [TRIG_W-1:0] x_nxt[3];
    logic signed [TRIG_W-1:0] y_nxt[3];
    logic signed [PH_W-1:0]   z_nxt[3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (!z_r[i][l][PH_W-1]) begin
          x_nxt[l] = x_r[i][l] - (y_r[i][l] >>> i);
          y_nxt[l] = y_r[i][l] + (x_r[i][l] >>> i);
          z_nxt[l] = z_r[i][l] - atan_phase(i);
        end else begin
          x_nxt[l] = x_r[i][l] + (y_r[i][l] >>> i);
          y_nxt[l] = y_r[i][l] - (x_r[i][l] >>> i);
          z_nxt[l] = z_r[i][l] + atan_phase(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        x_r[i+1][l] <= x_nxt[l];
        y_r[i+1][l] <= y_nxt[l];
        z_r[i+1][l] <= z_nxt[l];
      end
      flip_r[i+1] <= flip_r[i];
      pay_r[i+1]  <= pay_r[i];
    end
  end

  // Undo the fold by negating both results.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      c_r[l] <= flip_r[STEPS][l] ? -x_r[STEPS][l] : x_r[STEPS][l];
      s_r[l] <= flip_r[STEPS][l] ? -y_r[STEPS][l] : y_r[STEPS][l];
    end
    out_pay_r <= pay_r[STEPS];
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      v_r     <= {v_r[STEPS-1:0], in_v};
      out_v_r <= v_r[STEPS];
    end
  end

  assign out_v   = out_v_r;
  assign out_c   = c_r;
  assign out_s   = s_r;
  assign out_pay = out_pay_r;

endmodule

`default_nettype wire

[src/ccp_rot.sv]
// ----------------------------------------------------------------------------
// Plane rotation stage
// Rotates (a, b) by a Q24 cosine/sine pair in two register stages: four
// products, then the sums with a floor shift back to the vector width.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_rot
  import ccp_pkg::*;
#(
  parameter int AW = 26,
  parameter int PW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  logic signed [TRIG_W-1:0] in_c,
  input  logic signed [TRIG_W-1:0] in_s,
  input  logic signed [AW-1:0]    in_a,
  input  logic signed [AW-1:0]    in_b,
  input  logic [PW-1:0]           in_pay,
  output logic                    out_v,
  output logic signed [AW-1:0]    out_a,
  output logic signed [AW-1:0]    out_b,
  output logic [PW-1:0]           out_pay
);

  localparam int PRW = TRIG_W + AW;

  logic signed [PRW-1:0] ca_r, sb_r, cb_r, sa_r;
  logic [PW-1:0]         pay1_r, pay2_r;
  logic signed [PRW:0]   na_nxt, nb_nxt;
  logic signed [AW-1:0]  a_r, b_r;
  logic                  v1_r, v2_r;

  // Products.
  always_ff @(posedge clk) begin
    ca_r   <= in_c * in_a;
    sb_r   <= in_s * in_b;
    cb_r   <= in_c * in_b;
    sa_r   <= in_s * in_a;
    pay1_r <= in_pay;
  end

  // Sums and floor shift by the fraction width.
  always_comb begin
    na_nxt = $signed({ca_r[PRW-1], ca_r}) + $signed({sb_r[PRW-1], sb_r});
    nb_nxt = $signed({cb_r[PRW-1], cb_r}) - $signed({sa_r[PRW-1], sa_r});
  end

  always_ff @(posedge clk) begin
    a_r    <= na_nxt[AW+FRAC_W-1:FRAC_W];
    b_r    <= nb_nxt[AW+FRAC_W-1:FRAC_W];
    pay2_r <= pay1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  assign out_v   = v2_r;
  assign out_a   = a_r;
  assign out_b   = b_r;
  assign out_pay = pay2_r;

endmodule

`default_nettype wire

[src/ccp_vec.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Drives y to zero one step per register stage, returning the raw magnitude
// and the accumulated phase; an opaque word travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ccp_vec
  import ccp_pkg::*;
#(
  parameter int STEPS = 16,
  parameter int PW    = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic [PW-1:0]           in_pay,
  output logic                    out_v,
  output logic signed [VEC_W-1:0] out_m,
  output logic signed [PH_W-1:0]  out_ph,
  output logic [PW-1:0]           out_pay
);

  logic [STEPS-1:0]         v_r;
  logic signed [VEC_W-1:0]  x_r  [0:STEPS-1];
  logic signed [VEC_W-1:0]  y_r  [0:STEPS-1];
  logic signed [PH_W-1:0]   z_r  [0:STEPS-1];
  logic [PW-1:0]            pay_r[0:STEPS-1];
  logic signed [VEC_W-1:0]  ax   [0:STEPS];
  logic signed [VEC_W-1:0]  ay   [0:STEPS];
  logic signed [PH_W-1:0]   az   [0:STEPS];
  logic [PW-1:0]            ap   [0:STEPS];

  assign ax[0] = in_x;
  assign ay[0] = in_y;
  assign az[0] = '0;
  assign ap[0] = in_pay;

  // One micro-rotation per stage, direction from the sign of y.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [VEC_W-1:0] x_nxt, y_nxt;
    logic signed [PH_W-1:0]  z_nxt;

    always_comb begin
      if (!ay[i][VEC_W-1]) begin
        x_nxt = ax[i] + (ay[i] >>> i);
        y_nxt = ay[i] - (ax[i] >>> i);
        z_nxt = az[i] + atan_phase(i);
      end else begin
        x_nxt = ax[i] - (ay[i] >>> i);
        y_nxt = ay[i] + (ax[i] >>> i);
        z_nxt = az[i] - atan_phase(i);
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]   <= x_nxt;
      y_r[i]   <= y_nxt;
      z_r[i]   <= z_nxt;
      pay_r[i] <= ap[i];
    end

    assign ax[i+1] = x_r[i];
    assign ay[i+1] = y_r[i];
    assign az[i+1] = z_r[i];
    assign ap[i+1] = pay_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STEPS-2:0], in_v};
    end
  end

  assign out_v   = v_r[STEPS-1];
  assign out_m   = ax[STEPS];
  assign out_ph  = az[STEPS];
  assign out_pay = ap[STEPS];

endmodule

`default_nettype wire

[src/camera_pan_tilt_pointing.sv]
// ----------------------------------------------------------------------------
// Camera pan/tilt pointing
// Rotates the plane-to-target offset into the plane frame and returns the
// camera pan and tilt angles.
// ----------------------------------------------------------------------------
// Usage:
//   A word (plane and target positions plus heading, pitch and roll) is taken
//   at every clock edge where start is high and busy is low. busy stays low:
//   the pipeline takes a new word every cycle and never stalls.
//   Each word yields one result on out_pan_angle and out_tilt_angle, shown
//   for exactly one cycle with out_valid high, in input order.
//   The pipeline runs through the sine/cosine CORDIC, three two-stage
//   rotations, two normalizing stages, one operand stage, the pan vectoring
//   CORDIC, two magnitude gain stages, the tilt vectoring CORDIC and one
//   output stage. Throughput is one word per cycle.
//   Reset clears all valid bits, so no result appears until words arrive.
//   The receiver cannot hold results off; there is no backpressure path.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_pan_tilt_pointing
  import ccp_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [POSITION_BITS-1:0] in_plane_east,
  input  logic [POSITION_BITS-1:0] in_plane_north,
  input  logic [POSITION_BITS-1:0] in_plane_altitude,
  input  logic [ANG_W-1:0]         in_heading_angle,
  input  logic [ANG_W-1:0]         in_pitch_angle,
  input  logic [ANG_W-1:0]         in_roll_angle,
  input  logic [POSITION_BITS-1:0] in_target_east,
  input  logic [POSITION_BITS-1:0] in_target_north,
  input  logic [POSITION_BITS-1:0] in_target_altitude,
  output logic                     out_valid,
  output logic signed [ANG_W-1:0]  out_pan_angle,
  output logic signed [ANG_W-1:0]  out_tilt_angle
);

  localparam int PB  = POSITION_BITS;
  localparam int RW  = POSITION_BITS + 2;
  localparam int LAT = 3 * CORDIC_STEPS + 14;
  localparam int SC_PW  = 3 * RW;
  localparam int RH_PW  = RW + 4 * TRIG_W;
  localparam int RP_PW  = RW + 2 * TRIG_W;
  localparam int PAN_PW = NORM_W + 2;
  localparam int TLT_PW = ANG_W + 1;
  localparam int YZ0_D  = CORDIC_STEPS + 4;

  logic in_acc;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Offset vector, target minus plane: x north, y east, z altitude.
  logic signed [RW-1:0] dx, dy, dz;

  assign dx = $signed({{2{in_target_north[PB-1]}}, in_target_north}) -
              $signed({{2{in_plane_north[PB-1]}}, in_plane_north});
  assign dy = $signed({{2{in_target_east[PB-1]}}, in_target_east}) -
              $signed({{2{in_plane_east[PB-1]}}, in_plane_east});
  assign dz = $signed({{2{in_target_altitude[PB-1]}}, in_target_altitude}) -
              $signed({{2{in_plane_altitude[PB-1]}}, in_plane_altitude});

  // Sine and cosine of all three attitude angles.
  logic                   sc_v;
  logic [2:0][TRIG_W-1:0] sc_c, sc_s;
  logic [SC_PW-1:0]       sc_pay;

  ccp_sincos #(.STEPS(CORDIC_STEPS), .PW(SC_PW)) u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (in_acc),
    .in_ang  ({in_roll_angle, in_pitch_angle, in_heading_angle}),
    .in_pay  ({dx, dy, dz}),
    .out_v   (sc_v),
    .out_c   (sc_c),
    .out_s   (sc_s),
    .out_pay (sc_pay)
  );

  // Heading rotation on (x, y).
  logic                 rh_v;
  logic signed [RW-1:0] x1, y1;
  logic [RH_PW-1:0]     rh_pay;

  ccp_rot #(.AW(RW), .PW(RH_PW)) u_rot_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (sc_v),
    .in_c    ($signed(sc_c[0])),
    .in_s    ($signed(sc_s[0])),
    .in_a    ($signed(sc_pay[3*RW-1:2*RW])),
    .in_b    ($signed(sc_pay[2*RW-1:RW])),
    .in_pay  ({sc_pay[RW-1:0], sc_c[1], sc_s[1], sc_c[2], sc_s[2]}),
    .out_v   (rh_v),
    .out_a   (x1),
    .out_b   (y1),
    .out_pay (rh_pay)
  );

  // Pitch rotation on (x, z).
  logic                 rp_v;
  logic signed [RW-1:0] x2, z2;
  logic [RP_PW-1:0]     rp_pay;

  ccp_rot #(.AW(RW), .PW(RP_PW)) u_rot_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (rh_v),
    .in_c    ($signed(rh_pay[4*TRIG_W-1:3*TRIG_W])),
    .in_s    ($signed(rh_pay[3*TRIG_W-1:2*TRIG_W])),
    .in_a    (x1),
    .in_b    ($signed(rh_pay[RH_PW-1:4*TRIG_W])),
    .in_pay  ({y1, rh_pay[2*TRIG_W-1:0]}),
    .out_v   (rp_v),
    .out_a   (x2),
    .out_b   (z2),
    .out_pay (rp_pay)
  );

  // Roll rotation on (z, y).
  logic                 rr_v;
  logic signed [RW-1:0] z3, y3;
  logic [RW-1:0]        rr_pay;

  ccp_rot #(.AW(RW), .PW(RW)) u_rot_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (rp_v),
    .in_c    ($signed(rp_pay[2*TRIG_W-1:TRIG_W])),
    .in_s    ($signed(rp_pay[TRIG_W-1:0])),
    .in_a    (z2),
    .in_b    ($signed(rp_pay[RP_PW-1:2*TRIG_W])),
    .in_pay  (x2),
    .out_v   (rr_v),
    .out_a   (z3),
    .out_b   (y3),
    .out_pay (rr_pay)
  );

  // Normalize, first stage: find the shift that lifts the largest component
  // to at least 2^32. The OR of the magnitudes has the same top bit.
  logic [RW-1:0]        big;
  logic [SHIFT_W-1:0]   msb;
  logic [SHIFT_W-1:0]   sh_nxt;
  logic signed [RW-1:0] x3 ;

  assign x3 = $signed(rr_pay);

  always_comb begin
    big = (x3[RW-1] ? -x3 : x3) | (y3[RW-1] ? -y3 : y3) | (z3[RW-1] ? -z3 : z3);
    msb = '0;
    for (int b = 0; b < RW; b++) begin
      if (big[b]) begin
        msb = SHIFT_W'(b);
      end
    end
    if ((big != '0) && (msb < SHIFT_W'(NORM_EXP))) begin
      sh_nxt = SHIFT_W'(NORM_EXP) - msb;
    end else begin
      sh_nxt = '0;
    end
  end

  logic                 na_v_r;
  logic [SHIFT_W-1:0]   sh_r;
  logic signed [RW-1:0] xa_r, ya_r, za_r;

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    xa_r <= x3;
    ya_r <= y3;
    za_r <= z3;
  end

  // Normalize, second stage: apply the shift and note the special cases.
  logic                     nb_v_r;
  logic signed [NORM_W-1:0] xb_r, yb_r, zb_r;
  logic                     z0b_r, ynegb_r;

  always_ff @(posedge clk) begin
    xb_r    <= $signed({{(NORM_W-RW){xa_r[RW-1]}}, xa_r}) <<< sh_r;
    yb_r    <= $signed({{(NORM_W-RW){ya_r[RW-1]}}, ya_r}) <<< sh_r;
    zb_r    <= $signed({{(NORM_W-RW){za_r[RW-1]}}, za_r}) <<< sh_r;
    z0b_r   <= (za_r == '0);
    ynegb_r <= ya_r[RW-1];
  end

  // Pan operands: mirror into the right half plane when z is negative.
  logic                    pc_v_r;
  logic signed [VEC_W-1:0] px_r, py_r;
  logic [PAN_PW-1:0]       pc_pay_r;
  logic signed [VEC_W-1:0] zb_ext, yb_ext;

  assign zb_ext = $signed({{(VEC_W-NORM_W){zb_r[NORM_W-1]}}, zb_r});
  assign yb_ext = $signed({{(VEC_W-NORM_W){yb_r[NORM_W-1]}}, yb_r});

  always_ff @(posedge clk) begin
    px_r     <= zb_r[NORM_W-1] ? -zb_ext : zb_ext;
    py_r     <= zb_r[NORM_W-1] ? -yb_ext : yb_ext;
    pc_pay_r <= {xb_r, z0b_r, ynegb_r};
  end

  logic                    pv_v;
  logic signed [VEC_W-1:0] pv_m;
  logic signed [PH_W-1:0]  pv_ph;
  logic [PAN_PW-1:0]       pv_pay;

  ccp_vec #(.STEPS(CORDIC_STEPS), .PW(PAN_PW)) u_vec_pan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (pc_v_r),
    .in_x    (px_r),
    .in_y    (py_r),
    .in_pay  (pc_pay_r),
    .out_v   (pv_v),
    .out_m   (pv_m),
    .out_ph  (pv_ph),
    .out_pay (pv_pay)
  );

  // Pan angle and the two partial products of the magnitude gain.
  logic                         gd_v_r;
  logic signed [ANG_W-1:0]      pan_d_r;
  logic [GAIN_HI_W+FRAC_W-1:0]  phi_r;
  logic [GAIN_LO_W+FRAC_W-1:0]  plo_r;
  logic [NORM_W-1:0]            xd_r;
  logic [VEC_W-2:0]             m_clamp;
  logic signed [ANG_W-1:0]      pan_nxt;
  logic                         pv_z0, pv_yneg;

  assign pv_z0   = pv_pay[1];
  assign pv_yneg = pv_pay[0];
  assign m_clamp = pv_m[VEC_W-1] ? '0 : pv_m[VEC_W-2:0];

  always_comb begin
    if (pv_z0) begin
      pan_nxt = pv_yneg ? HALF_PI_OUT : -HALF_PI_OUT;
    end else begin
      pan_nxt = -phase_to_out(pv_ph);
    end
  end

  always_ff @(posedge clk) begin
    pan_d_r <= pan_nxt;
    phi_r   <= m_clamp[VEC_W-2:GAIN_LO_W] * GAIN_Q24;
    plo_r   <= m_clamp[GAIN_LO_W-1:0] * GAIN_Q24;
    xd_r    <= pv_pay[PAN_PW-1:2];
  end

  // Gain-corrected magnitude, floor shifted by the fraction width.
  localparam int GSUM_W = GAIN_HI_W + FRAC_W + GAIN_LO_W + 1;

  logic                    ge_v_r;
  logic signed [VEC_W-1:0] re_r;
  logic signed [VEC_W-1:0] xe_r;
  logic [ANG_W-1:0]        te_pay_r;
  logic [GSUM_W-1:0]       gsum;

  assign gsum = {1'b0, phi_r, {GAIN_LO_W{1'b0}}} +
                {{(GSUM_W-GAIN_LO_W-FRAC_W){1'b0}}, plo_r};

  always_ff @(posedge clk) begin
    re_r     <= $signed(gsum[VEC_W+FRAC_W-1:FRAC_W]);
    xe_r     <= $signed({{(VEC_W-NORM_W){xd_r[NORM_W-1]}}, xd_r});
    te_pay_r <= pan_d_r;
  end

  // The zero y and z case is tracked from the normalize stage onward; the
  // last tap lines up with the gain stage that feeds the tilt CORDIC.
  logic [YZ0_D-1:0] yz0_pipe_r;
  logic             yz0_b;

  assign yz0_b = (ya_r == '0) && (za_r == '0);

  always_ff @(posedge clk) begin
    yz0_pipe_r <= {yz0_pipe_r[YZ0_D-2:0], yz0_b};
  end

  logic                    tv_v;
  logic signed [VEC_W-1:0] tv_m;
  logic signed [PH_W-1:0]  tv_ph;
  logic [TLT_PW-1:0]       tv_pay;

  ccp_vec #(.STEPS(CORDIC_STEPS), .PW(TLT_PW)) u_vec_tilt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (ge_v_r),
    .in_x    (re_r),
    .in_y    (xe_r),
    .in_pay  ({te_pay_r, yz0_pipe_r[YZ0_D-1]}),
    .out_v   (tv_v),
    .out_m   (tv_m),
    .out_ph  (tv_ph),
    .out_pay (tv_pay)
  );

  // Output word; the zero y and z case gives a pan of minus a quarter turn and a tilt of a quarter turn.
  logic                    out_v_r;
  logic signed [ANG_W-1:0] pan_r, tilt_r;
  logic                    tv_unused;

  assign tv_unused = ^tv_m;

  always_ff @(posedge clk) begin
    if (tv_pay[0]) begin
      pan_r  <= -HALF_PI_OUT;
      tilt_r <= HALF_PI_OUT;
    end else begin
      pan_r  <= $signed(tv_pay[TLT_PW-1:1]);
      tilt_r <= phase_to_out(tv_ph) ^ {ANG_W{tv_unused & 1'b0}};
    end
  end

  // Valid bits of the stages kept here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_v_r  <= 1'b0;
      nb_v_r  <= 1'b0;
      pc_v_r  <= 1'b0;
      gd_v_r  <= 1'b0;
      ge_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      na_v_r  <= rr_v;
      nb_v_r  <= na_v_r;
      pc_v_r  <= nb_v_r;
      gd_v_r  <= pv_v;
      ge_v_r  <= gd_v_r;
      out_v_r <= tv_v;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pan_angle  = pan_r;
  assign out_tilt_angle = tilt_r;

  // Every word taken at the input must come out as a result with out_valid high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_acc, LAT) && $past(rst_n, LAT)) |-> out_valid)
    else $error("result missing at the pipeline latency");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, LAT)) |-> $past(in_acc, LAT))
    else $error("result without a matching input word");

  a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pan_angle <= HALF_PI_OUT && out_pan_angle >= -HALF_PI_OUT))
    else $error("pan angle beyond a quarter turn");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tilt_angle <= HALF_PI_OUT && out_tilt_angle >= -HALF_PI_OUT))
    else $error("tilt angle beyond a quarter turn");

  a_nb_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rr_v |=> ##2 pc_v_r)
    else $error("normalize stages lost a valid word");

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Camera pan/tilt pointing testbench
// Drives directed and random-burst position and attitude words, predicts pan
// and tilt with a bit-exact fixed-point model and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ccp_pkg::*;

  localparam int STEPS        = 16;
  localparam int POS_W        = 24;
  localparam int LATENCY      = 3 * STEPS + 14;
  localparam int RANDOM_WORDS = 1650;
  localparam int IDLE_LIMIT   = 2000;
  localparam longint GAIN     = 64'd10187457;
  localparam longint NORM_TOP = 64'sd1 << 32;

  typedef struct {
    logic [POS_W-1:0] plane_e, plane_n, plane_a;
    logic [ANG_W-1:0] heading, pitch, roll;
    logic [POS_W-1:0] target_e, target_n, target_a;
  } pointing_word_t;

  typedef struct {
    logic signed [ANG_W-1:0] pan;
    logic signed [ANG_W-1:0] tilt;
  } gimbal_angles_t;

  // Arctangent table as a 64-bit signed phase.
  function automatic longint atan_step(input int i);
    longint t[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  // Q24 cosine and sine of a binary angle, folded into the right half plane.
  function automatic void trig_q24(input logic [ANG_W-1:0] ang,
                                   output longint c, output longint s);
    logic [31:0] p;
    logic [1:0]  q;
    bit          flip;
    longint      x, y, z, dx, dy;
    p = {ang, 16'h0000};
    q = p[31:30];
    flip = (q == 2'd1 || q == 2'd2);
    if (flip) p = p + 32'h80000000;
    z = longint'($signed(p));
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void rotate_pair(input longint c, input longint s,
                                      inout longint a, inout longint b);
    longint na, nb;
    na = (c * a + s * b) >>> 24;
    nb = (c * b - s * a) >>> 24;
    a = na;
    b = nb;
  endfunction

  // Vectoring CORDIC: phase of (x, y) and raw magnitude.
  function automatic longint vector_phase(input longint x0, input longint y0,
                                          output longint m);
    longint x, y, z, dx, dy;
    x = x0; y = y0; z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    m = x;
    return z;
  endfunction

  function automatic longint phase_angle(input longint ph);
    longint v;
    v = (ph + 32768) >>> 16;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  function automatic longint labs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Pan and tilt for one word.
  function automatic gimbal_angles_t pointing_angles(input pointing_word_t w);
    gimbal_angles_t r;
    longint x, y, z, c, s, big, m, mg, ph, pan, tilt;
    x = longint'($signed(w.target_n)) - longint'($signed(w.plane_n));
    y = longint'($signed(w.target_e)) - longint'($signed(w.plane_e));
    z = longint'($signed(w.target_a)) - longint'($signed(w.plane_a));
    trig_q24(w.heading, c, s);
    rotate_pair(c, s, x, y);
    trig_q24(w.pitch, c, s);
    rotate_pair(c, s, x, z);
    trig_q24(w.roll, c, s);
    rotate_pair(c, s, z, y);
    big = labs(x);
    if (labs(y) > big) big = labs(y);
    if (labs(z) > big) big = labs(z);
    while (big != 0 && big < NORM_TOP) begin
      x *= 2; y *= 2; z *= 2; big *= 2;
    end
    if (y == 0 && z == 0) begin
      pan = -16384;
      tilt = 16384;
    end else begin
      ph = (z < 0) ? vector_phase(-z, -y, m) : vector_phase(z, y, m);
      if (z == 0) pan = (y >= 0) ? -16384 : 16384;
      else pan = -phase_angle(ph);
      if (m < 0) m = 0;
      mg = (m * GAIN) >>> 24;
      tilt = phase_angle(vector_phase(mg, x, m));
    end
    r.pan = pan[ANG_W-1:0];
    r.tilt = tilt[ANG_W-1:0];
    return r;
  endfunction

  // Holds predicted angles in input order and checks results against them.
  class angle_scoreboard;
    gimbal_angles_t pending[$];
    int errors;

    function void note_word(pointing_word_t w);
      pending.push_back(pointing_angles(w));
    endfunction

    function void check_result(logic signed [ANG_W-1:0] pan,
                               logic signed [ANG_W-1:0] tilt);
      gimbal_angles_t e;
      if (pending.size() == 0) begin
        $error("unexpected result pan=%0d tilt=%0d", pan, tilt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pan !== e.pan) begin
        $error("pan_angle expected %0d actual %0d", e.pan, pan);
        errors++;
      end
      if (tilt !== e.tilt) begin
        $error("tilt_angle expected %0d actual %0d", e.tilt, tilt);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start;
  logic busy, out_valid;
  logic signed [ANG_W-1:0] out_pan_angle, out_tilt_angle;
  pointing_word_t drv;
  angle_scoreboard board;
  int idle_cycles;

  camera_pan_tilt_pointing u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_plane_east(drv.plane_e), .in_plane_north(drv.plane_n),
    .in_plane_altitude(drv.plane_a), .in_heading_angle(drv.heading),
    .in_pitch_angle(drv.pitch), .in_roll_angle(drv.roll),
    .in_target_east(drv.target_e), .in_target_north(drv.target_n),
    .in_target_altitude(drv.target_a),
    .out_valid(out_valid), .out_pan_angle(out_pan_angle),
    .out_tilt_angle(out_tilt_angle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_pan_angle, out_tilt_angle);
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one word and holds it until it is taken.
  task automatic send_word(input pointing_word_t w);
    start <= 1'b1;
    drv <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(w);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return POS_W'($urandom_range(0, 15)) - 8;
      1: return {1'b1, 23'h0};
      2: return {1'b0, {23{1'b1}}};
      3: return POS_W'($urandom_range(0, 4095)) - 2048;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return ANG_W'($urandom_range(0, 3)) << 14;
      1: return ANG_W'($urandom_range(0, 31)) - 16;
      default: return ANG_W'($urandom);
    endcase
  endfunction

  function automatic pointing_word_t rand_word();
    pointing_word_t w;
    w.plane_e = rand_pos(); w.plane_n = rand_pos(); w.plane_a = rand_pos();
    w.heading = rand_angle(); w.pitch = rand_angle(); w.roll = rand_angle();
    w.target_e = rand_pos(); w.target_n = rand_pos(); w.target_a = rand_pos();
    // Target often equal to the plane in some axes to hit zero offsets.
    if ($urandom_range(0, 5) == 0) w.target_a = w.plane_a;
    if ($urandom_range(0, 7) == 0) w.target_e = w.plane_e;
    if ($urandom_range(0, 9) == 0) w.target_n = w.plane_n;
    return w;
  endfunction

  function automatic pointing_word_t make_word(input int dx, input int dy,
      input int dz, input logic [ANG_W-1:0] h, input logic [ANG_W-1:0] p,
      input logic [ANG_W-1:0] r);
    pointing_word_t w;
    w.plane_e = '0; w.plane_n = '0; w.plane_a = '0;
    w.target_n = POS_W'(dx); w.target_e = POS_W'(dy); w.target_a = POS_W'(dz);
    w.heading = h; w.pitch = p; w.roll = r;
    return w;
  endfunction

  initial begin
    pointing_word_t w;
    int burst;
    board = new();
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    drv = '{default: '0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: zero offset, axis targets, zero altitude, field extremes.
    send_word(make_word(0, 0, 0, 0, 0, 0));
    send_word(make_word(100, 0, 0, 0, 0, 0));
    send_word(make_word(0, 50, 0, 0, 0, 0));
    send_word(make_word(0, -50, 0, 0, 0, 0));
    send_word(make_word(0, 0, -300, 0, 0, 0));
    send_word(make_word(0, 0, 300, 0, 0, 0));
    send_word(make_word(10, 20, -30, 16'h4000, 16'h0000, 16'h0000));
    send_word(make_word(10, 20, -30, 16'h8000, 16'h4000, 16'hC000));
    send_word(make_word(10, 20, -30, 16'h7FFF, 16'hFFFF, 16'h0001));
    send_word(make_word(1, 1, 1, 16'h2000, 16'hE000, 16'h6000));
    w = make_word(0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    w.plane_e = {1'b1, 23'h0}; w.plane_n = {1'b1, 23'h0}; w.plane_a = {1'b1, 23'h0};
    w.target_e = {1'b0, {23{1'b1}}}; w.target_n = {1'b0, {23{1'b1}}};
    w.target_a = {1'b0, {23{1'b1}}};
    send_word(w);
    w.plane_e = {1'b0, {23{1'b1}}}; w.plane_n = {1'b0, {23{1'b1}}};
    w.plane_a = {1'b0, {23{1'b1}}}; w.target_e = {1'b1, 23'h0};
    w.target_n = {1'b1, 23'h0}; w.target_a = {1'b1, 23'h0};
    w.heading = 16'h7FFF; w.pitch = 16'h7FFF; w.roll = 16'h7FFF;
    send_word(w);
    send_word(make_word(0, 5, 0, 0, 16'h4000, 0));
    send_word(make_word(-7, 0, 0, 0, 0, 16'h4000));

    // Random words in bursts with random gaps.
    for (int n = 0; n < RANDOM_WORDS; ) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                          : $urandom_range(1, 10);
      for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++)
        send_word(rand_word());
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    start <= 1'b0;

    // Drain the pipeline.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
